/* rtl/lsrk_pkg.sv */
// Shared types and constants for the LIFO stack with remove-by-key.
// No dependencies; every other file imports this package.
package lsrk_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int KEY_BITS_DEF = 64;

  // Operation codes carried by a request transaction
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Status codes returned in a response transaction
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // What every cell in the row does this cycle
  typedef enum logic [1:0] {
    CM_HOLD,
    CM_PUSH,
    CM_POP,
    CM_REMOVE
  } cell_mode_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] name_key;
    logic [7:0]  entry_age;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [4:0]  entry_count;
    logic [63:0] top_name;
    logic [7:0]  top_age;
  } rsp_t;

endpackage

/* rtl/lsrk_cell.sv */
// One stack slot: holds a key and an age, shifts toward or away from the top.
// Depends on lsrk_pkg (cell_mode_t).
module lsrk_cell #(
  parameter int KEY_BITS = lsrk_pkg::KEY_BITS_DEF
) (
  input  logic                   clk,
  input  lsrk_pkg::cell_mode_t   mode,
  input  logic                   held,       // slot lies below the fill count
  input  logic [KEY_BITS-1:0]    search_key,
  input  logic [KEY_BITS-1:0]    up_key,     // neighbor nearer the top
  input  logic [7:0]             up_age,
  input  logic [KEY_BITS-1:0]    dn_key,     // neighbor farther from the top
  input  logic [7:0]             dn_age,
  input  logic                   found_in,   // match seen in a slot nearer the top
  output logic                   found_out,
  output logic [KEY_BITS-1:0]    key,
  output logic [7:0]             age,
  output logic [KEY_BITS-1:0]    key_next,
  output logic [7:0]             age_next
);
  import lsrk_pkg::*;

  // First match from the top: this slot and all below it close the gap
  assign found_out = found_in | (held && (key == search_key));

  always_comb begin
    key_next = key;
    age_next = age;
    unique case (mode)
      CM_PUSH: begin
        key_next = up_key;
        age_next = up_age;
      end
      CM_POP: begin
        key_next = dn_key;
        age_next = dn_age;
      end
      CM_REMOVE: begin
        if (found_out) begin
          key_next = dn_key;
          age_next = dn_age;
        end
      end
      default: begin
      end
    endcase
  end

  // Payload only, no reset: slots beyond the fill count are never reported
  always_ff @(posedge clk) begin
    key <= key_next;
    age <= age_next;
  end

endmodule

/* rtl/lifo_stack_remove_by_key_core.sv */
// Top level of the LIFO stack with remove-by-key: control, fill count, cell row.
// Depends on lsrk_pkg and lsrk_cell.
//
//  channel | signals                     | direction | payload
//  --------+-----------------------------+-----------+----------------------------
//  request | req_valid, req_ready, req   | in        | op, name_key, entry_age
//  response| rsp_valid, rsp_ready, rsp   | out       | status, count, top entry
//
// One transaction per cycle while the response side keeps up: the cell row searches all
// slots and shifts in the same cycle it accepts a request; the response is registered at that edge.
// A request is taken whenever the response register is empty or being drained.
// Synchronous reset empties the stack and the response register, no clearing pass.
// A stalled response holds its payload; requests wait until it is taken.
module lifo_stack_remove_by_key_core #(
  parameter int DEPTH    = lsrk_pkg::DEPTH_DEF,
  parameter int KEY_BITS = lsrk_pkg::KEY_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  lsrk_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output lsrk_pkg::rsp_t rsp
);
  import lsrk_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          is_empty;
  logic          is_full;
  cell_mode_t    mode;
  status_t       status;
  logic [KEY_BITS-1:0] req_key;

  logic [KEY_BITS-1:0] key_q    [DEPTH];
  logic [7:0]          age_q    [DEPTH];
  logic [KEY_BITS-1:0] key_n    [DEPTH];
  logic [7:0]          age_n    [DEPTH];
  logic [DEPTH:0]      found;

  logic [CW+4:0]       count_ext;
  logic [KEY_BITS+63:0] top_ext;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign is_empty  = (count == '0);
  assign is_full   = (count == CW'(DEPTH));
  assign req_key   = req.name_key[KEY_BITS-1:0];

  // Decode operation into cell mode, status and next fill count
  always_comb begin
    mode       = CM_HOLD;
    status     = ST_OK;
    count_next = count;
    if (accept) begin
      unique case (req.op)
        OP_PUSH: begin
          if (is_full) begin
            status = ST_FULL;
          end else begin
            mode       = CM_PUSH;
            count_next = count + CW'(1);
          end
        end
        OP_POP: begin
          if (is_empty) begin
            status = ST_EMPTY;
          end else begin
            mode       = CM_POP;
            count_next = count - CW'(1);
          end
        end
        OP_REMOVE: begin
          if (is_empty) begin
            status = ST_EMPTY;
          end else begin
            mode = CM_REMOVE;
            if (found[DEPTH]) count_next = count - CW'(1);
            else status = ST_NOTFOUND;
          end
        end
        OP_CLEAR: begin
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Row of cells, slot 0 is the top of the stack
  assign found[0] = 1'b0;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic [KEY_BITS-1:0] up_key;
    logic [7:0]          up_age;
    logic [KEY_BITS-1:0] dn_key;
    logic [7:0]          dn_age;

    if (j == 0) begin : g_top
      assign up_key = req_key;
      assign up_age = req.entry_age;
    end else begin : g_mid
      assign up_key = key_q[j-1];
      assign up_age = age_q[j-1];
    end

    if (j == DEPTH - 1) begin : g_bot
      assign dn_key = '0;
      assign dn_age = '0;
    end else begin : g_nbot
      assign dn_key = key_q[j+1];
      assign dn_age = age_q[j+1];
    end

    lsrk_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk       (clk),
      .mode      (mode),
      .held      (count > CW'(j)),
      .search_key(req_key),
      .up_key    (up_key),
      .up_age    (up_age),
      .dn_key    (dn_key),
      .dn_age    (dn_age),
      .found_in  (found[j]),
      .found_out (found[j+1]),
      .key       (key_q[j]),
      .age       (age_q[j]),
      .key_next  (key_n[j]),
      .age_next  (age_n[j])
    );
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else     count <= count_next;
  end

  // Response register
  assign count_ext = {5'b0, count_next};
  assign top_ext   = {64'b0, key_n[0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status      <= status;
      rsp.entry_count <= count_ext[4:0];
      if (count_next == '0) begin
        rsp.top_name <= '0;
        rsp.top_age  <= '0;
      end else begin
        rsp.top_name <= top_ext[63:0];
        rsp.top_age  <= age_n[0];
      end
    end
  end

endmodule

/* sim/tb.sv */
// Testbench for lifo_stack_remove_by_key_core: directed table then random traffic,
// every response checked against a table entry or an in-bench stack predictor. Depends on lsrk_pkg.
module tb;
  import lsrk_pkg::*;

  localparam int          DEPTH       = DEPTH_DEF;
  localparam int          KEY_BITS    = KEY_BITS_DEF;
  localparam logic [63:0] KEY_MASK    = (KEY_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                         : ((64'd1 << KEY_BITS) - 64'd1);
  localparam int          RAND_ITEMS  = 1500;
  localparam int          MAX_IDLE    = 6;
  localparam int          CYCLE_LIMIT = 200000;

  // One row of the directed table; result is used only where typed is set
  typedef struct {
    req_t item;
    bit   typed;
    rsp_t result;
  } dir_row_t;

  // What the monitor needs to know about each driven transaction
  typedef struct {
    bit   typed;
    rsp_t result;
  } item_note_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Predictor state: a plain array stack
  logic [63:0] key_mem [DEPTH];
  logic [7:0]  age_mem [DEPTH];
  int          held = 0;

  dir_row_t    dir_rows[$];
  item_note_t  item_note_q[$];
  rsp_t        expected_rsp_q[$];
  logic [63:0] key_pool [16];
  int          error_count = 0;
  int          cycle_count = 0;

  lifo_stack_remove_by_key_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one operation to the predicted stack and return the response it gives
  function automatic rsp_t apply_stack_op(req_t item);
    rsp_t        r;
    logic [63:0] key;
    int          pos;
    key = item.name_key & KEY_MASK;
    r   = '0;
    r.status = ST_OK;
    pos = -1;
    case (item.op)
      OP_PUSH: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          key_mem[held] = key;
          age_mem[held] = item.entry_age;
          held++;
        end
      end
      OP_POP: begin
        if (held == 0) r.status = ST_EMPTY;
        else held--;
      end
      OP_REMOVE: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // search from the top, first hit wins
          for (int i = held - 1; i >= 0 && pos < 0; i--)
            if (key_mem[i] == key) pos = i;
          if (pos < 0) begin
            r.status = ST_NOTFOUND;
          end else begin
            for (int i = pos; i + 1 < held; i++) begin
              key_mem[i] = key_mem[i + 1];
              age_mem[i] = age_mem[i + 1];
            end
            held--;
          end
        end
      end
      default: held = 0;
    endcase
    r.entry_count = 5'(held);
    if (held > 0) begin
      r.top_name = key_mem[held - 1];
      r.top_age  = age_mem[held - 1];
    end
    return r;
  endfunction

  function automatic void add_row(op_t op, logic [63:0] key, logic [7:0] age,
                                  bit typed, rsp_t result);
    dir_row_t row;
    row.item   = '{op: op, name_key: key, entry_age: age};
    row.typed  = typed;
    row.result = result;
    dir_rows.push_back(row);
  endfunction

  // Random request: pool keys make remove hits and duplicates common
  function automatic req_t make_random_req(bit fill_phase);
    req_t        r;
    int          pick;
    logic [63:0] key;
    pick = $urandom_range(0, 99);
    if (fill_phase)
      r.op = (pick < 60) ? OP_PUSH : (pick < 75) ? OP_POP : (pick < 97) ? OP_REMOVE : OP_CLEAR;
    else
      r.op = (pick < 25) ? OP_PUSH : (pick < 60) ? OP_POP : (pick < 97) ? OP_REMOVE : OP_CLEAR;
    if ($urandom_range(0, 99) < 78) key = key_pool[$urandom_range(0, 15)];
    else key = {$urandom, $urandom};
    r.name_key  = key;
    r.entry_age = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // Present one transaction after a random gap (none in a burst) and wait for it to be taken
  task automatic send_item(req_t item, bit typed, rsp_t result, bit burst);
    int         gap;
    item_note_t note;
    gap = burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    note.typed  = typed;
    note.result = result;
    item_note_q.push_back(note);
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Stimulus: reset, directed table, random traffic, drain
  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 16; i++) key_pool[i] = {$urandom, $urandom};

    // empty-stack cases right after reset
    add_row(OP_POP,    64'h0,  8'h00, 1, rsp_t'{ST_EMPTY, 5'd0, 64'h0, 8'h00});
    add_row(OP_REMOVE, '1,     8'hFF, 1, rsp_t'{ST_EMPTY, 5'd0, 64'h0, 8'h00});
    add_row(OP_CLEAR,  '1,     8'hFF, 1, rsp_t'{ST_OK,    5'd0, 64'h0, 8'h00});
    // field extremes, a miss, removal of the bottom entry
    add_row(OP_PUSH,   '1,     8'hFF, 1, rsp_t'{ST_OK,    5'd1, '1,    8'hFF});
    add_row(OP_PUSH,   64'h0,  8'h00, 1, rsp_t'{ST_OK,    5'd2, 64'h0, 8'h00});
    add_row(OP_REMOVE, 64'h5,  8'h00, 1, rsp_t'{ST_NOTFOUND, 5'd2, 64'h0, 8'h00});
    add_row(OP_REMOVE, '1,     8'h00, 1, rsp_t'{ST_OK,    5'd1, 64'h0, 8'h00});
    add_row(OP_POP,    64'h0,  8'h00, 1, rsp_t'{ST_OK,    5'd0, 64'h0, 8'h00});
    // fill to depth, then push when full
    for (int i = 0; i < DEPTH; i++)
      add_row(OP_PUSH, 64'hC0DE_0000_0000_0000 | 64'(i), 8'(16 * i + 1), 0, '0);
    add_row(OP_PUSH, 64'h8000_0000_0000_0001, 8'h80, 1,
            rsp_t'{ST_FULL, 5'(DEPTH), 64'hC0DE_0000_0000_000F, 8'd241});
    // remove from the middle and from the top, then clear a full-ish stack
    add_row(OP_REMOVE, 64'hC0DE_0000_0000_0007, 8'h00, 0, '0);
    add_row(OP_REMOVE, 64'hC0DE_0000_0000_000F, 8'h00, 0, '0);
    add_row(OP_POP,    64'h0, 8'h00, 0, '0);
    add_row(OP_CLEAR,  64'h0, 8'h00, 1, rsp_t'{ST_OK, 5'd0, 64'h0, 8'h00});
    add_row(OP_PUSH,   64'h0123_4567_89AB_CDEF, 8'h5A, 0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result, 1'b0);

    for (int n = 0; n < RAND_ITEMS; n++)
      send_item(make_random_req(((n / 48) % 2) == 0), 1'b0, '0, ((n / 100) % 4) == 3);
    req_valid <= 1'b0;

    // let the request monitor record the last transaction before draining
    @(posedge clk);
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Response side: random stall before taking each transaction, none in some stretches
  initial begin : rsp_drain
    int stall;
    int taken;
    taken = 0;
    forever begin
      stall = (((taken / 90) % 4) == 2) ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!(rsp_valid && !rst)) @(posedge clk);
      taken++;
    end
  end

  // Request monitor: predict every accepted transaction
  always @(posedge clk) begin
    item_note_t note;
    rsp_t       predicted;
    if (!rst && req_valid && req_ready) begin
      note      = item_note_q.pop_front();
      predicted = apply_stack_op(req);
      expected_rsp_q.push_back(note.typed ? note.result : predicted);
    end
  end

  // Response monitor: compare field by field with the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp_q.size() == 0) begin
        $error("unexpected response transaction: status %0d count %0d",
               rsp.status, rsp.entry_count);
        error_count++;
      end else begin
        want = expected_rsp_q.pop_front();
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp.status);
          error_count++;
        end
        if (rsp.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, rsp.entry_count);
          error_count++;
        end
        if (rsp.top_name !== want.top_name) begin
          $error("top_name: expected %h, actual %h", want.top_name, rsp.top_name);
          error_count++;
        end
        if (rsp.top_age !== want.top_age) begin
          $error("top_age: expected %0d, actual %0d", want.top_age, rsp.top_age);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
